// File: rtl/sha512_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and tables of the SHA-512 / SHA-384 hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int WordW   = 64;
  localparam int NumWins = 16;   // message schedule words in a block
  localparam int Rounds  = 80;
  localparam int RndW    = 7;
  localparam int FillW   = 7;    // byte count within a 128-byte block

  localparam logic [7:0]       PadByte    = 8'h80;
  localparam logic [FillW-1:0] LenStart   = 7'd120;
  localparam logic [FillW-1:0] SpillStart = 7'd112;
  localparam logic [FillW-1:0] LastSlot   = 7'd127;
  localparam logic [RndW-1:0]  LastRound  = 7'(Rounds - 1);

  localparam logic VarSha512 = 1'b0;
  localparam logic VarSha384 = 1'b1;

  localparam logic [2:0] LastIdx512 = 3'd7;
  localparam logic [2:0] LastIdx384 = 3'd5;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic push_in;    // shift the input byte into the block
    logic push_pad;   // shift the next padding byte into the block
    logic comp_init;  // load working variables from the chaining state
    logic round;      // one compression round
    logic comp_add;   // fold working variables into the chaining state
    logic finish;     // digest delivered: reload IV, clear counters
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic block_full;  // the next byte completes the block
    logic final_slot;  // padding has reached the length bytes of the last block
    logic variant;
  } dp_stat_t;

  function automatic logic [63:0] iv_word(input logic variant, input logic [2:0] idx);
    logic [63:0] w;
    if (variant == VarSha384) begin
      case (idx)
        3'd0: w = 64'hcbbb9d5dc1059ed8;
        3'd1: w = 64'h629a292a367cd507;
        3'd2: w = 64'h9159015a3070dd17;
        3'd3: w = 64'h152fecd8f70e5939;
        3'd4: w = 64'h67332667ffc00b31;
        3'd5: w = 64'h8eb44a8768581511;
        3'd6: w = 64'hdb0c2e0d64f98fa7;
        default: w = 64'h47b5481dbefa4fa4;
      endcase
    end else begin
      case (idx)
        3'd0: w = 64'h6a09e667f3bcc908;
        3'd1: w = 64'hbb67ae8584caa73b;
        3'd2: w = 64'h3c6ef372fe94f82b;
        3'd3: w = 64'ha54ff53a5f1d36f1;
        3'd4: w = 64'h510e527fade682d1;
        3'd5: w = 64'h9b05688c2b3e6c1f;
        3'd6: w = 64'h1f83d9abfb41bd6b;
        default: w = 64'h5be0cd19137e2179;
      endcase
    end
    return w;
  endfunction

  function automatic logic [63:0] round_k(input logic [RndW-1:0] t);
    logic [63:0] k;
    case (t)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sha512_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_dp
// Datapath: block shift line doubling as schedule window, working
// variables, chaining state, length counter and padding bookkeeping.
// ----------------------------------------------------------------------------
module sha512_dp
  import sha512_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [7:0]  in_byte,
  input  wire logic [RndW-1:0] rnd,
  input  wire logic [2:0]  rd_idx,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  output dp_stat_t         stat,
  output logic [63:0]      digest_word
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [NumWins*WordW-1:0] win;       // word 0 in the top bits
  logic [63:0]      chain [8];
  logic [63:0]      v     [8];
  logic [FillW-1:0] fill;
  logic [63:0]      total_bits;
  logic             sent80;
  logic             spill;
  logic             variant;

  logic        len_phase;
  logic [7:0]  pad_byte;
  logic [7:0]  push_byte;
  logic        push;
  logic [63:0] w0, w1, w9, w14, wnew, s0, s1;
  logic [63:0] t1, t2;

  assign len_phase = !spill && (fill >= LenStart);
  assign pad_byte  = !sent80 ? PadByte :
                     len_phase ? total_bits[{~fill[2:0], 3'b000} +: 8] : 8'h00;
  assign push_byte = cmd.push_in ? in_byte : pad_byte;
  assign push      = cmd.push_in || cmd.push_pad;

  assign w0  = win[NumWins*WordW-1 -: WordW];
  assign w1  = win[(NumWins-1)*WordW-1 -: WordW];
  assign w9  = win[(NumWins-9)*WordW-1 -: WordW];
  assign w14 = win[(NumWins-14)*WordW-1 -: WordW];
  assign s0  = rotr(w1, 1) ^ rotr(w1, 8) ^ (w1 >> 7);
  assign s1  = rotr(w14, 19) ^ rotr(w14, 61) ^ (w14 >> 6);
  assign wnew = s1 + w9 + s0 + w0;

  assign t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w0;
  assign t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (push) begin
      win <= {win[NumWins*WordW-9:0], push_byte};
    end else if (cmd.round) begin
      // window slides one word; the tail takes W[t+16]
      win <= {win[(NumWins-1)*WordW-1:0], wnew};
    end
    if (cmd.comp_init) begin
      for (int j = 0; j < 8; j++) v[j] <= chain[j];
    end else if (cmd.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      total_bits <= '0;
      sent80     <= 1'b0;
      spill      <= 1'b0;
      variant    <= VarSha512;
      for (int j = 0; j < 8; j++) chain[j] <= iv_word(VarSha512, 3'(j));
    end else begin
      if (push) fill <= fill + 7'd1;
      if (cmd.push_in) total_bits <= total_bits + 64'd8;
      if (cmd.push_pad && !sent80) begin
        sent80 <= 1'b1;
        spill  <= (fill >= SpillStart) && (fill != LastSlot);
      end else if (push && fill == LastSlot) begin
        spill <= 1'b0;
      end
      if (cmd.comp_add) begin
        for (int j = 0; j < 8; j++) chain[j] <= chain[j] + v[j];
      end
      if (cmd.finish) begin
        fill       <= '0;
        total_bits <= '0;
        sent80     <= 1'b0;
        spill      <= 1'b0;
        for (int j = 0; j < 8; j++) chain[j] <= iv_word(variant, 3'(j));
      end
      if (cfg_we) begin
        variant <= cfg_data;
        if (fill == '0 && total_bits == '0) begin
          for (int j = 0; j < 8; j++) chain[j] <= iv_word(cfg_data, 3'(j));
        end
      end
    end
  end

  assign stat.block_full = (fill == LastSlot);
  assign stat.final_slot = sent80 && len_phase;
  assign stat.variant    = variant;
  assign digest_word     = chain[rd_idx];

endmodule
`default_nettype wire

// File: rtl/sha512_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_ctrl
// Controller: sequences byte intake, padding, the 80 rounds and the
// digest word output.
// ----------------------------------------------------------------------------
module sha512_ctrl
  import sha512_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      msg_valid,
  output logic           msg_ready,
  input  wire in_item_t  msg,
  output logic           dig_valid,
  input  wire logic      dig_ready,
  input  wire dp_stat_t  stat,
  output dp_cmd_t        cmd,
  output logic [RndW-1:0] rnd,
  output logic [2:0]     idx,
  output logic           last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic       finishing;   // end mark seen, padding still owed
  logic       go_out;      // block in flight carries the length
  logic       take;

  assign msg_ready = (state == S_IDLE);
  assign take      = msg_valid && msg_ready;
  assign dig_valid = (state == S_OUT);
  assign last      = (idx == ((stat.variant == VarSha384) ? LastIdx384 : LastIdx512));

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cmd.push_in  = take && msg.has_byte;
    cmd.push_pad = (state == S_PAD);
    cmd.comp_init = (state == S_INIT);
    cmd.round    = (state == S_ROUND);
    cmd.comp_add = (state == S_ADD);
    cmd.finish   = dig_valid && dig_ready && last;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (msg.has_byte && stat.block_full) state_next = S_INIT;
          else if (msg.end_of_message)         state_next = S_PAD;
        end
      end
      S_PAD:   if (stat.block_full) state_next = S_INIT;
      S_INIT:  state_next = S_ROUND;
      S_ROUND: if (rnd == LastRound) state_next = S_ADD;
      S_ADD: begin
        if (go_out)         state_next = S_OUT;
        else if (finishing) state_next = S_PAD;
        else                state_next = S_IDLE;
      end
      S_OUT:   if (cmd.finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finishing <= 1'b0;
      go_out    <= 1'b0;
      rnd       <= '0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (take && msg.end_of_message) finishing <= 1'b1;
      if (state == S_PAD && stat.block_full && stat.final_slot) go_out <= 1'b1;
      if (state == S_ROUND) rnd <= (rnd == LastRound) ? '0 : rnd + 7'd1;
      if (dig_valid && dig_ready) idx <= last ? 3'd0 : idx + 3'd1;
      if (cmd.finish) begin
        finishing <= 1'b0;
        go_out    <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("input taken while digest pending");

  a_full_starts_comp: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_in || cmd.push_pad) && stat.block_full |=> state == S_INIT)
    else $error("full block not compressed");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state != S_ROUND |-> rnd == '0)
    else $error("round counter not parked");

  a_out_after_add: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> $past(state) == S_ADD && idx == 3'd0)
    else $error("digest out of sequence");
`endif

endmodule
`default_nettype wire

// File: rtl/sha512_sha384_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_sha384_hasher
// SHA-512 / SHA-384 message hasher, byte-wide input, 64-bit digest words.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle, while idle, into a 128-byte shift line. A
// full block holds off input through load, 80 rounds of the single round
// unit and fold into the chaining state. On the end mark padding goes in one
// byte per cycle up to the block end, then one or, with 112 or more bytes
// held, two compressions follow; the digest comes out as 8 words (6 for
// SHA-384), one per accepted word, after which the next message may start.
// The variant register loads the initial values when written between messages.
module sha512_sha384_hasher
  import sha512_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     msg_valid,
  output logic          msg_ready,
  input  wire in_item_t msg,
  output logic          dig_valid,
  input  wire logic     dig_ready,
  output out_item_t     dig,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [RndW-1:0] rnd;
  logic [2:0]      idx;
  logic            last;
  logic [63:0]     word;

  assign cfg_ready = 1'b1;

  sha512_ctrl u_ctrl (
    .clk, .rst, .msg_valid, .msg_ready, .msg, .dig_valid, .dig_ready,
    .stat, .cmd, .rnd, .idx, .last
  );

  sha512_dp u_dp (
    .clk, .rst, .cmd,
    .in_byte     (msg.msg_byte),
    .rnd,
    .rd_idx      (idx),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data,
    .stat,
    .digest_word (word)
  );

  assign dig.digest_word = word;
  assign dig.word_index  = idx;
  assign dig.last_word   = last;

endmodule
`default_nettype wire
